[hw/rtl/tts_pkg.sv]
`timescale 1ns / 1ps

package tts_pkg;

  localparam int COLUMNS = 70;
  localparam int ROWS = 30;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [2:0] {
    ACT_PUT    = 3'd0,
    ACT_WIP    = 3'd1,
    ACT_BACK   = 3'd2,
    ACT_SETPOS = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] char_val;
    logic              scroll;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_beat_t;

  function automatic logic [ROW_W-1:0] phys_row(logic [ROW_W-1:0] r, logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(logic [ROW_W-1:0] r);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS));
  endfunction

endpackage

[hw/rtl/tts_screen_ram.sv]
`timescale 1ns / 1ps

module tts_screen_ram (
  input  logic                               clk,
  input  tts_pkg::mem_req_t                  req,
  output logic [tts_pkg::CHAR_W-1:0]         rdata
);

  logic [tts_pkg::CHAR_W-1:0] mem [tts_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[hw/rtl/tts_core.sv]
`timescale 1ns / 1ps

module tts_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [tts_pkg::CHAR_W-1:0]     char_code,
  input  logic [tts_pkg::ROW_W-1:0]      target_row,
  input  logic [tts_pkg::COL_W-1:0]      target_col,
  input  logic                           slot_free,
  output tts_pkg::res_beat_t             beat,
  output tts_pkg::mem_req_t              req,
  input  logic [tts_pkg::CHAR_W-1:0]     rdata
);

  localparam int AW = tts_pkg::ADDR_W;
  localparam int RW = tts_pkg::ROW_W;
  localparam int CW = tts_pkg::COL_W;

  tts_pkg::state_t state, state_next;
  logic [RW-1:0] row, row_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] top, top_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] clr_last, clr_last_next;

  logic          accept;
  logic [RW-1:0] tr;
  logic [CW-1:0] tc;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] tgt_addr;
  logic          nl;
  logic          scroll;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tts_pkg::ST_CLEAR;
      row      <= '0;
      col      <= '0;
      top      <= '0;
      clr_addr <= '0;
      clr_last <= AW'(tts_pkg::CELLS - 1);
    end else begin
      state    <= state_next;
      row      <= row_next;
      col      <= col_next;
      top      <= top_next;
      clr_addr <= clr_addr_next;
      clr_last <= clr_last_next;
    end
  end

  always_comb begin
    in_stall = !(state == tts_pkg::ST_IDLE && slot_free);
    accept   = in_valid && !in_stall;

    tr = (target_row >= RW'(tts_pkg::ROWS)) ? RW'(tts_pkg::ROWS - 1) : target_row;
    tc = (target_col >= CW'(tts_pkg::COLUMNS)) ? CW'(tts_pkg::COLUMNS - 1) : target_col;
    cur_addr = tts_pkg::row_base(tts_pkg::phys_row(row, top)) + AW'(col);
    tgt_addr = tts_pkg::row_base(tts_pkg::phys_row(tr, top)) + AW'(tc);

    state_next    = state;
    row_next      = row;
    col_next      = col;
    top_next      = top;
    clr_addr_next = clr_addr;
    clr_last_next = clr_last;
    nl            = 1'b0;
    scroll        = 1'b0;

    req       = '0;
    req.wdata = char_code;
    req.waddr = cur_addr;
    req.raddr = tgt_addr;
    beat      = '0;

    unique case (state)
      tts_pkg::ST_CLEAR: begin
        req.we        = 1'b1;
        req.waddr     = clr_addr;
        req.wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == clr_last) begin
          state_next = tts_pkg::ST_IDLE;
        end
      end
      tts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action)
            tts_pkg::ACT_PUT: begin
              if (char_code == tts_pkg::NEWLINE_CODE) begin
                nl = 1'b1;
              end else begin
                req.we = 1'b1;
                if (col >= CW'(tts_pkg::COLUMNS - 1)) begin
                  nl = 1'b1;
                end else begin
                  col_next = col + CW'(1);
                end
              end
            end
            tts_pkg::ACT_WIP: begin
              req.we = 1'b1;
            end
            tts_pkg::ACT_BACK: begin
              if (col != '0) begin
                col_next = col - CW'(1);
              end
            end
            tts_pkg::ACT_SETPOS: begin
              row_next = tr;
              col_next = tc;
            end
            tts_pkg::ACT_READ: begin
              req.re     = 1'b1;
              state_next = tts_pkg::ST_READ;
            end
            default: begin
            end
          endcase

          if (nl) begin
            col_next = '0;
            if (row >= RW'(tts_pkg::ROWS - 1)) begin
              scroll        = 1'b1;
              row_next      = RW'(tts_pkg::ROWS - 1);
              top_next      = tts_pkg::phys_row(RW'(1), top);
              clr_addr_next = tts_pkg::row_base(top);
              clr_last_next = tts_pkg::row_base(top) + AW'(tts_pkg::COLUMNS - 1);
              state_next    = tts_pkg::ST_CLEAR;
            end else begin
              row_next = row + RW'(1);
            end
          end

          beat.push         = (action != tts_pkg::ACT_READ);
          beat.res.row      = row_next;
          beat.res.col      = col_next;
          beat.res.char_val = '0;
          beat.res.scroll   = scroll;
        end
      end
      tts_pkg::ST_READ: begin
        beat.push         = 1'b1;
        beat.res.row      = row;
        beat.res.col      = col;
        beat.res.char_val = rdata;
        beat.res.scroll   = 1'b0;
        state_next        = tts_pkg::ST_IDLE;
      end
      default: begin
        state_next = tts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/text_terminal_cursor_scroll_unit.sv]
// A result reaches the output register in the cycle after its input beat; a read_cell result passes
// the memory read register first and holds off new beats until it is pushed. Other beats are taken
// one per cycle unless the output register is held or a clear runs. A scroll rotates the row map and
// then clears the new bottom row, one cell per cycle. The screen memory has a single write port,
// which sets the clearing rate. Reset is synchronous and active high; a clearing pass then zeroes
// all 2100 cells, during which in_stall stays high. The cursor and row map reset to zero.
`timescale 1ns / 1ps

module text_terminal_cursor_scroll_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [tts_pkg::CHAR_W-1:0]     char_code,
  input  logic [tts_pkg::ROW_W-1:0]      target_row,
  input  logic [tts_pkg::COL_W-1:0]      target_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tts_pkg::ROW_W-1:0]      cursor_row_now,
  output logic [tts_pkg::COL_W-1:0]      cursor_col_now,
  output logic [tts_pkg::CHAR_W-1:0]     cell_value,
  output logic                           did_scroll
);

  tts_pkg::mem_req_t             req;
  tts_pkg::res_beat_t            beat;
  logic [tts_pkg::CHAR_W-1:0]    rdata;
  logic                          slot_free;

  assign slot_free = !out_valid || !out_stall;

  tts_screen_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  tts_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .char_code  (char_code),
    .target_row (target_row),
    .target_col (target_col),
    .slot_free  (slot_free),
    .beat       (beat),
    .req        (req),
    .rdata      (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.push) begin
      cursor_row_now <= beat.res.row;
      cursor_col_now <= beat.res.col;
      cell_value     <= beat.res.char_val;
      did_scroll     <= beat.res.scroll;
    end
  end

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == tts_pkg::ACT_READ |=> in_stall)
    else $error("input taken while a cell read was in flight");

  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && did_scroll |->
      cursor_row_now == tts_pkg::ROWS - 1 && cursor_col_now == 0)
    else $error("scroll result with cursor off the start of the last row");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_row_now < tts_pkg::ROWS && cursor_col_now < tts_pkg::COLUMNS)
    else $error("cursor outside the screen");

  a_reset_clear: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken before the clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    beat.push |-> slot_free)
    else $error("result pushed into an occupied output register");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] ACT_LAST = 3'd7;
  localparam int MAX_GAP = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 650;

  typedef struct packed {
    logic [2:0]                 act;
    logic [tts_pkg::CHAR_W-1:0] code;
    logic [tts_pkg::ROW_W-1:0]  row;
    logic [tts_pkg::COL_W-1:0]  col;
  } term_cmd_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [2:0]                 action = '0;
  logic [tts_pkg::CHAR_W-1:0] char_code = '0;
  logic [tts_pkg::ROW_W-1:0]  target_row = '0;
  logic [tts_pkg::COL_W-1:0]  target_col = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [tts_pkg::ROW_W-1:0]  cursor_row_now;
  logic [tts_pkg::COL_W-1:0]  cursor_col_now;
  logic [tts_pkg::CHAR_W-1:0] cell_value;
  logic                       did_scroll;

  term_cmd_t          cmd_queue[$];
  tts_pkg::result_t   expected_results[$];
  term_cmd_t          next_cmd;
  tts_pkg::result_t   want;

  logic [tts_pkg::CHAR_W-1:0] screen_model[tts_pkg::CELLS];
  int cur_row = 0;
  int cur_col = 0;

  int errors = 0;
  int beats_sent = 0;
  int send_wait = 0;
  bit send_burst = 1'b0;
  int recv_wait = 0;
  bit recv_burst = 1'b0;
  logic hold_output = 1'b0;

  text_terminal_cursor_scroll_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .char_code      (char_code),
    .target_row     (target_row),
    .target_col     (target_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row_now (cursor_row_now),
    .cursor_col_now (cursor_col_now),
    .cell_value     (cell_value),
    .did_scroll     (did_scroll)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit line_feed();
    int i;
    if (cur_row >= tts_pkg::ROWS - 1) begin
      for (i = 0; i < tts_pkg::CELLS - tts_pkg::COLUMNS; i++) begin
        screen_model[i] = screen_model[i + tts_pkg::COLUMNS];
      end
      for (i = tts_pkg::CELLS - tts_pkg::COLUMNS; i < tts_pkg::CELLS; i++) begin
        screen_model[i] = '0;
      end
      cur_row = tts_pkg::ROWS - 1;
      cur_col = 0;
      return 1'b1;
    end
    cur_row++;
    cur_col = 0;
    return 1'b0;
  endfunction

  function automatic tts_pkg::result_t terminal_step(term_cmd_t c);
    tts_pkg::result_t r;
    int row_c;
    int col_c;
    row_c = (c.row >= tts_pkg::ROWS) ? tts_pkg::ROWS - 1 : int'(c.row);
    col_c = (c.col >= tts_pkg::COLUMNS) ? tts_pkg::COLUMNS - 1 : int'(c.col);
    r = '0;
    case (c.act)
      tts_pkg::ACT_PUT: begin
        if (c.code == tts_pkg::NEWLINE_CODE) begin
          r.scroll = line_feed();
        end else begin
          screen_model[cur_row * tts_pkg::COLUMNS + cur_col] = c.code;
          if (cur_col >= tts_pkg::COLUMNS - 1) begin
            r.scroll = line_feed();
          end else begin
            cur_col++;
          end
        end
      end
      tts_pkg::ACT_WIP: begin
        screen_model[cur_row * tts_pkg::COLUMNS + cur_col] = c.code;
      end
      tts_pkg::ACT_BACK: begin
        if (cur_col != 0) begin
          cur_col--;
        end
      end
      tts_pkg::ACT_SETPOS: begin
        cur_row = row_c;
        cur_col = col_c;
      end
      tts_pkg::ACT_READ: begin
        r.char_val = screen_model[row_c * tts_pkg::COLUMNS + col_c];
      end
      default: begin
      end
    endcase
    r.row = tts_pkg::ROW_W'(cur_row);
    r.col = tts_pkg::COL_W'(cur_col);
    return r;
  endfunction

  task automatic add_cmd(input logic [2:0] a, input logic [tts_pkg::CHAR_W-1:0] c,
                         input logic [tts_pkg::ROW_W-1:0] r,
                         input logic [tts_pkg::COL_W-1:0] k);
    term_cmd_t t;
    t.act = a;
    t.code = c;
    t.row = r;
    t.col = k;
    cmd_queue.push_back(t);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        next_cmd.act = action;
        next_cmd.code = char_code;
        next_cmd.row = target_row;
        next_cmd.col = target_col;
        expected_results.push_back(terminal_step(next_cmd));
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          next_cmd = cmd_queue.pop_front();
          action <= next_cmd.act;
          char_code <= next_cmd.code;
          target_row <= next_cmd.row;
          target_col <= next_cmd.col;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            send_burst = !send_burst;
          end
          send_wait = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: row %0d col %0d cell %0d scroll %0d",
                   $time, cursor_row_now, cursor_col_now, cell_value, did_scroll);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (cursor_row_now !== want.row) begin
            $display("%0t: cursor_row_now expected %0d, actual %0d",
                     $time, want.row, cursor_row_now);
            errors++;
          end
          if (cursor_col_now !== want.col) begin
            $display("%0t: cursor_col_now expected %0d, actual %0d",
                     $time, want.col, cursor_col_now);
            errors++;
          end
          if (cell_value !== want.char_val) begin
            $display("%0t: cell_value expected %0d, actual %0d",
                     $time, want.char_val, cell_value);
            errors++;
          end
          if (did_scroll !== want.scroll) begin
            $display("%0t: did_scroll expected %0d, actual %0d",
                     $time, want.scroll, did_scroll);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) begin
          recv_burst = !recv_burst;
        end
        recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= hold_output || (recv_wait > 0);
    end
  end

  // The receiver stops taking results for a long stretch so that the block backs up.
  initial begin
    wait (beats_sent >= 150);
    @(posedge clk);
    hold_output <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_output <= 1'b0;
    wait (beats_sent >= 450);
    @(posedge clk);
    hold_output <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_output <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int counted;
    int pick;
    foreach (screen_model[i]) begin
      screen_model[i] = '0;
    end

    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_PUT, 8'h41, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_PUT, 8'hFF, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_PUT, 8'h00, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_WIP, tts_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd0, 7'd3);
    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd0, 7'd1);
    add_cmd(tts_pkg::ACT_BACK, 8'h00, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_SETPOS, 8'h00, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_BACK, 8'hFF, 5'd31, 7'd127);
    add_cmd(tts_pkg::ACT_SETPOS, 8'h00, 5'd5, 7'd69);
    add_cmd(tts_pkg::ACT_PUT, 8'h7E, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_PUT, tts_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_SETPOS, 8'h00, 5'd31, 7'd127);
    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd31, 7'd127);
    add_cmd(tts_pkg::ACT_PUT, 8'h80, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd28, 7'd69);
    add_cmd(tts_pkg::ACT_PUT, 8'h5A, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_PUT, tts_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd29, 7'd0);
    add_cmd(tts_pkg::ACT_READ, 8'h00, 5'd27, 7'd69);
    add_cmd(3'(tts_pkg::ACT_READ + 1), 8'hAA, 5'd21, 7'd85);
    add_cmd(ACT_LAST, 8'h55, 5'd10, 7'd42);
    add_cmd(tts_pkg::ACT_SETPOS, 8'h00, 5'd29, 7'd0);
    add_cmd(tts_pkg::ACT_BACK, 8'h00, 5'd0, 7'd0);

    // Mostly text with line feeds, positioned near the bottom often enough to scroll.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_cmd(tts_pkg::ACT_PUT, ($urandom_range(0, 7) == 0) ? tts_pkg::NEWLINE_CODE
                : tts_pkg::CHAR_W'($urandom_range(0, 255)),
                tts_pkg::ROW_W'($urandom), tts_pkg::COL_W'($urandom));
      end else if (pick < 67) begin
        add_cmd(tts_pkg::ACT_READ, tts_pkg::CHAR_W'($urandom),
                tts_pkg::ROW_W'($urandom_range(0, 31)),
                tts_pkg::COL_W'($urandom_range(0, 127)));
      end else if (pick < 76) begin
        add_cmd(tts_pkg::ACT_SETPOS, tts_pkg::CHAR_W'($urandom),
                ($urandom_range(0, 1) == 1) ? tts_pkg::ROW_W'($urandom_range(25, 31))
                : tts_pkg::ROW_W'($urandom_range(0, 31)),
                ($urandom_range(0, 1) == 1) ? tts_pkg::COL_W'($urandom_range(60, 127))
                : tts_pkg::COL_W'($urandom_range(0, 3)));
      end else if (pick < 84) begin
        add_cmd(tts_pkg::ACT_WIP, tts_pkg::CHAR_W'($urandom_range(0, 255)),
                tts_pkg::ROW_W'($urandom), tts_pkg::COL_W'($urandom));
      end else if (pick < 94) begin
        add_cmd(tts_pkg::ACT_BACK, tts_pkg::CHAR_W'($urandom),
                tts_pkg::ROW_W'($urandom), tts_pkg::COL_W'($urandom));
      end else begin
        add_cmd(3'($urandom_range(tts_pkg::ACT_READ + 1, ACT_LAST)),
                tts_pkg::CHAR_W'($urandom),
                tts_pkg::ROW_W'($urandom), tts_pkg::COL_W'($urandom));
        counted--;
      end
      counted++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tts_pkg.sv
hw/rtl/tts_screen_ram.sv
hw/rtl/tts_core.sv
hw/rtl/text_terminal_cursor_scroll_unit.sv
tb/sv/tb.sv
